@@ rtl/tekd_pkg.sv @@
// tekd_pkg: types, codes and helper functions of the terminal escape key decoder.
// No dependencies; imported by tekd_parse, terminal_escape_key_decoder and tekd_checker.
package tekd_pkg;

    localparam int NUMBER_BITS = 16;
    localparam int TIME_BITS   = 32;

    typedef logic [NUMBER_BITS-1:0] t_num;
    typedef logic [TIME_BITS-1:0]   t_time;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_ESC       = 9'b000000010,
        PH_CSI_START = 9'b000000100,
        PH_CSI_NUM   = 9'b000001000,
        PH_CSI_SEP   = 9'b000010000,
        PH_SS3       = 9'b000100000,
        PH_SGR_B     = 9'b001000000,
        PH_SGR_X     = 9'b010000000,
        PH_SGR_Y     = 9'b100000000
    } t_phase;

    localparam logic [1:0] EV_KEY        = 2'd0;
    localparam logic [1:0] EV_MOUSE_DOWN = 2'd1;
    localparam logic [1:0] EV_MOUSE_UP   = 2'd2;
    localparam logic [1:0] EV_SCROLL     = 2'd3;

    localparam logic [4:0] K_UP     = 5'd0;
    localparam logic [4:0] K_DOWN   = 5'd1;
    localparam logic [4:0] K_LEFT   = 5'd2;
    localparam logic [4:0] K_RIGHT  = 5'd3;
    localparam logic [4:0] K_HOME   = 5'd4;
    localparam logic [4:0] K_END    = 5'd5;
    localparam logic [4:0] K_TAB    = 5'd6;
    localparam logic [4:0] K_INSERT = 5'd7;
    localparam logic [4:0] K_DELETE = 5'd8;
    localparam logic [4:0] K_PGUP   = 5'd9;
    localparam logic [4:0] K_PGDN   = 5'd10;
    localparam logic [4:0] K_F1     = 5'd11;
    localparam logic [4:0] K_ESCAPE = 5'd23;
    localparam logic [4:0] K_ENTER  = 5'd24;
    localparam logic [4:0] K_BKSP   = 5'd25;
    localparam logic [4:0] K_CTRL   = 5'd26;
    localparam logic [4:0] K_CHAR   = 5'd27;
    localparam logic [4:0] K_NONE   = 5'd31;

    localparam logic [7:0] B_BS       = 8'd8;
    localparam logic [7:0] B_TAB      = 8'd9;
    localparam logic [7:0] B_LF       = 8'd10;
    localparam logic [7:0] B_CR       = 8'd13;
    localparam logic [7:0] B_CTRL_Z   = 8'd26;
    localparam logic [7:0] B_ESC      = 8'd27;
    localparam logic [7:0] B_SPACE    = 8'd32;
    localparam logic [7:0] B_ZERO     = 8'd48;
    localparam logic [7:0] B_NINE     = 8'd57;
    localparam logic [7:0] B_SEMI     = 8'd59;
    localparam logic [7:0] B_LT       = 8'd60;
    localparam logic [7:0] B_UPPER_A  = 8'd65;
    localparam logic [7:0] B_UPPER_B  = 8'd66;
    localparam logic [7:0] B_UPPER_C  = 8'd67;
    localparam logic [7:0] B_UPPER_D  = 8'd68;
    localparam logic [7:0] B_UPPER_F  = 8'd70;
    localparam logic [7:0] B_UPPER_H  = 8'd72;
    localparam logic [7:0] B_UPPER_M  = 8'd77;
    localparam logic [7:0] B_UPPER_O  = 8'd79;
    localparam logic [7:0] B_UPPER_P  = 8'd80;
    localparam logic [7:0] B_UPPER_S  = 8'd83;
    localparam logic [7:0] B_UPPER_Z  = 8'd90;
    localparam logic [7:0] B_LBRACKET = 8'd91;
    localparam logic [7:0] B_LOWER_A  = 8'd97;
    localparam logic [7:0] B_TILDE    = 8'd126;
    localparam logic [7:0] B_DEL      = 8'd127;

    localparam logic [7:0] SGR_SCROLL_UP = 8'd64;
    localparam logic [7:0] SGR_SCROLL_DN = 8'd65;

    typedef struct packed {
        logic       valid;
        logic       track;
        logic [1:0] kind;
        logic [4:0] code;
        logic [6:0] ch;
        logic       sh;
        logic       ct;
        logic       al;
        t_num       mx;
        t_num       my;
        logic [1:0] btn;
        logic       scroll_dn;
    } t_evt;

    function automatic t_num sat_num(input t_num v, input logic [3:0] d);
        logic [NUMBER_BITS+3:0] p;
        p = {4'b0, v} * (NUMBER_BITS+4)'(10) + (NUMBER_BITS+4)'(d);
        return (|p[NUMBER_BITS+3:NUMBER_BITS]) ? '1 : p[NUMBER_BITS-1:0];
    endfunction

    function automatic logic [7:0] sat_byte(input logic [7:0] v, input logic [3:0] d);
        logic [11:0] p;
        p = {4'b0, v} * 12'd10 + {8'b0, d};
        return (|p[11:8]) ? 8'hFF : p[7:0];
    endfunction

    function automatic logic [4:0] tilde_key(input t_num p);
        logic [4:0] k;
        case (p)
            t_num'(1):  k = K_HOME;
            t_num'(2):  k = K_INSERT;
            t_num'(3):  k = K_DELETE;
            t_num'(4):  k = K_END;
            t_num'(5):  k = K_PGUP;
            t_num'(6):  k = K_PGDN;
            t_num'(11): k = K_F1;
            t_num'(12): k = K_F1 + 5'd1;
            t_num'(13): k = K_F1 + 5'd2;
            t_num'(14): k = K_F1 + 5'd3;
            t_num'(15): k = K_F1 + 5'd4;
            t_num'(17): k = K_F1 + 5'd5;
            t_num'(18): k = K_F1 + 5'd6;
            t_num'(19): k = K_F1 + 5'd7;
            t_num'(20): k = K_F1 + 5'd8;
            t_num'(21): k = K_F1 + 5'd9;
            t_num'(23): k = K_F1 + 5'd10;
            t_num'(24): k = K_F1 + 5'd11;
            default:    k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/tekd_if.sv @@
// tekd_in_if / tekd_out_if: valid-ready channels of the key decoder.
// No dependencies.
interface tekd_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  data_byte;
    logic [31:0] time_ms;

    modport source (output valid, output op, output data_byte, output time_ms, input ready);
    modport sink   (input valid, input op, input data_byte, input time_ms, output ready);
endinterface

interface tekd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [4:0]  key_code;
    logic [6:0]  character;
    logic        shift;
    logic        ctrl;
    logic        alt;
    logic        repeat_res;
    logic [15:0] mouse_x;
    logic [15:0] mouse_y;
    logic [1:0]  mouse_button;
    logic        scroll_down;

    modport source (output valid, output event_kind, output key_code, output character,
                    output shift, output ctrl, output alt, output repeat_res, output mouse_x,
                    output mouse_y, output mouse_button, output scroll_down, input ready);
    modport sink   (input valid, input event_kind, input key_code, input character,
                    input shift, input ctrl, input alt, input repeat_res, input mouse_x,
                    input mouse_y, input mouse_button, input scroll_down, output ready);
endinterface

@@ rtl/tekd_parse.sv @@
// tekd_parse: escape-sequence state machine and parameter registers.
// Depends on tekd_pkg; produces at most one decoded event per stepped byte.
module tekd_parse import tekd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_op,
    input  logic [7:0] i_byte,
    output t_evt       o_evt
);

    t_phase     r_phase,  n_phase;
    t_num       r_first,  n_first;
    t_num       r_second, n_second;
    logic [1:0] r_count,  n_count;
    logic [7:0] r_btn,    n_btn;
    t_num       r_col,    n_col;
    t_num       r_row,    n_row;

    logic       is_digit;
    logic [3:0] digit;
    logic [1:0] count_inc;
    logic [1:0] fin_count;
    t_num       mod_m;
    logic       mods_on;
    logic [4:0] csi_code;
    logic       csi_sh;
    logic       csi_ct;
    logic       csi_al;
    t_evt       csi_evt;
    t_evt       mouse_evt;

    function automatic t_evt mk_key(input logic [4:0] code, input logic [6:0] ch,
                                    input logic sh, input logic ct, input logic al);
        t_evt e;
        e       = '0;
        e.valid = 1'b1;
        e.track = 1'b1;
        e.kind  = EV_KEY;
        e.code  = code;
        e.ch    = ch;
        e.sh    = sh;
        e.ct    = ct;
        e.al    = al;
        return e;
    endfunction

    assign is_digit  = (i_byte >= B_ZERO) && (i_byte <= B_NINE);
    assign digit     = i_byte[3:0];
    assign count_inc = (r_count == 2'd3) ? 2'd3 : r_count + 2'd1;
    assign fin_count = (r_phase == PH_CSI_NUM) ? count_inc : r_count;
    assign mod_m     = r_second - t_num'(1);
    assign mods_on   = (fin_count >= 2'd2) && (r_second != '0);

    always_comb begin
        csi_code = K_NONE;
        csi_sh   = 1'b0;
        csi_ct   = 1'b0;
        csi_al   = 1'b0;
        if (i_byte >= B_UPPER_A && i_byte <= B_UPPER_D) begin
            csi_sh = mods_on & mod_m[0];
            csi_al = mods_on & mod_m[1];
            csi_ct = mods_on & mod_m[2];
            if (i_byte == B_UPPER_A) begin
                csi_code = K_UP;
            end else if (i_byte == B_UPPER_B) begin
                csi_code = K_DOWN;
            end else if (i_byte == B_UPPER_C) begin
                csi_code = K_RIGHT;
            end else begin
                csi_code = K_LEFT;
            end
        end else if (i_byte == B_UPPER_H) begin
            csi_code = K_HOME;
        end else if (i_byte == B_UPPER_F) begin
            csi_code = K_END;
        end else if (i_byte == B_UPPER_Z) begin
            csi_code = K_TAB;
            csi_sh   = 1'b1;
        end else if (i_byte == B_TILDE) begin
            csi_code = tilde_key((fin_count != 2'd0) ? r_first : '0);
        end
        csi_evt = (csi_code == K_NONE) ? '0 : mk_key(csi_code, 7'd0, csi_sh, csi_ct, csi_al);
    end

    always_comb begin
        mouse_evt       = '0;
        mouse_evt.valid = 1'b1;
        mouse_evt.mx    = r_col;
        mouse_evt.my    = r_row;
        if (r_btn == SGR_SCROLL_UP || r_btn == SGR_SCROLL_DN) begin
            mouse_evt.kind      = EV_SCROLL;
            mouse_evt.scroll_dn = (r_btn == SGR_SCROLL_DN);
        end else begin
            mouse_evt.kind = (i_byte == B_UPPER_M) ? EV_MOUSE_DOWN : EV_MOUSE_UP;
            mouse_evt.btn  = (r_btn <= 8'd2) ? r_btn[1:0] + 2'd1 : 2'd0;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        n_count  = r_count;
        n_btn    = r_btn;
        n_col    = r_col;
        n_row    = r_row;
        o_evt    = '0;
        if (i_op) begin
            n_phase = PH_IDLE;
            if (r_phase == PH_ESC) begin
                o_evt       = '0;
                o_evt.valid = 1'b1;
                o_evt.kind  = EV_KEY;
                o_evt.code  = K_ESCAPE;
            end
        end else begin
            case (r_phase)
                PH_ESC: begin
                    if (i_byte == B_LBRACKET) begin
                        n_first  = '0;
                        n_second = '0;
                        n_count  = 2'd0;
                        n_phase  = PH_CSI_START;
                    end else if (i_byte == B_UPPER_O) begin
                        n_phase = PH_SS3;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_SS3: begin
                    n_phase = PH_IDLE;
                    if (i_byte >= B_UPPER_P && i_byte <= B_UPPER_S) begin
                        o_evt = mk_key(K_F1 + 5'(i_byte - B_UPPER_P), 7'd0, 1'b0, 1'b0, 1'b0);
                    end else if (i_byte == B_UPPER_H) begin
                        o_evt = mk_key(K_HOME, 7'd0, 1'b0, 1'b0, 1'b0);
                    end else if (i_byte == B_UPPER_F) begin
                        o_evt = mk_key(K_END, 7'd0, 1'b0, 1'b0, 1'b0);
                    end
                end
                PH_CSI_START, PH_CSI_SEP: begin
                    if (is_digit) begin
                        if (r_count == 2'd0) begin
                            n_first = sat_num(r_first, digit);
                        end else if (r_count == 2'd1) begin
                            n_second = sat_num(r_second, digit);
                        end
                        n_phase = PH_CSI_NUM;
                    end else if (r_phase == PH_CSI_START && i_byte == B_LT) begin
                        n_btn   = 8'd0;
                        n_col   = '0;
                        n_row   = '0;
                        n_phase = PH_SGR_B;
                    end else begin
                        n_phase = PH_IDLE;
                        o_evt   = csi_evt;
                    end
                end
                PH_CSI_NUM: begin
                    if (is_digit) begin
                        if (r_count == 2'd0) begin
                            n_first = sat_num(r_first, digit);
                        end else if (r_count == 2'd1) begin
                            n_second = sat_num(r_second, digit);
                        end
                    end else begin
                        n_count = count_inc;
                        if (i_byte == B_SEMI) begin
                            n_phase = PH_CSI_SEP;
                        end else begin
                            n_phase = PH_IDLE;
                            o_evt   = csi_evt;
                        end
                    end
                end
                PH_SGR_B: begin
                    if (is_digit) begin
                        n_btn = sat_byte(r_btn, digit);
                    end else begin
                        n_phase = PH_SGR_X;
                    end
                end
                PH_SGR_X: begin
                    if (is_digit) begin
                        n_col = sat_num(r_col, digit);
                    end else begin
                        n_phase = PH_SGR_Y;
                    end
                end
                PH_SGR_Y: begin
                    if (is_digit) begin
                        n_row = sat_num(r_row, digit);
                    end else begin
                        n_phase = PH_IDLE;
                        o_evt   = mouse_evt;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_byte == B_ESC) begin
                        n_phase = PH_ESC;
                    end else if (i_byte == B_CR || i_byte == B_LF) begin
                        o_evt = mk_key(K_ENTER, 7'd0, 1'b0, 1'b0, 1'b0);
                    end else if (i_byte == B_TAB) begin
                        o_evt = mk_key(K_TAB, 7'd0, 1'b0, 1'b0, 1'b0);
                    end else if (i_byte == B_DEL || i_byte == B_BS) begin
                        o_evt = mk_key(K_BKSP, 7'd0, 1'b0, 1'b0, 1'b0);
                    end else if (i_byte >= 8'd1 && i_byte <= B_CTRL_Z) begin
                        o_evt = mk_key(K_CTRL, 7'(B_LOWER_A + i_byte - 8'd1),
                                       1'b0, 1'b1, 1'b0);
                    end else if (i_byte >= B_SPACE && i_byte < B_DEL) begin
                        o_evt = mk_key(K_CHAR, i_byte[6:0], 1'b0, 1'b0, 1'b0);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_first  <= '0;
            r_second <= '0;
            r_count  <= 2'd0;
            r_btn    <= 8'd0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_count  <= n_count;
            r_btn    <= n_btn;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

@@ rtl/terminal_escape_key_decoder.sv @@
// terminal_escape_key_decoder: terminal bytes in, key and mouse events out.
// Depends on tekd_pkg, tekd_if (tekd_in_if, tekd_out_if) and tekd_parse.
//
//  port      dir  handshake     carries
//  i_in      in   valid/ready   op, data_byte, time_ms
//  o_out     out  valid/ready   event_kind .. scroll_down (zero or one per item)
//  i_cfg_*   in   write enable  repeat_window_ms
//
// One item per cycle sustained while o_out is not stalled; each item passes from the input
// register through the parse stage to the result register.
// Synchronous active-low reset: idle phase, no previous key, window 50 ms.
// A stalled result holds; the input register refills while the result drains.
module terminal_escape_key_decoder import tekd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tekd_in_if.sink      i_in,
    tekd_out_if.source   o_out,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_data
);

    logic        r_in_valid;
    logic        r_op;
    logic [7:0]  r_byte;
    t_time       r_time;

    logic        r_out_valid;
    t_evt        r_out;
    logic        r_out_rep;

    logic [15:0] r_window;
    logic [4:0]  r_last_code;
    logic [6:0]  r_last_char;
    logic        r_last_valid;
    t_time       r_last_time;

    logic        advance;
    logic        step;
    t_evt        evt;
    t_time       elapsed;
    logic        rep;

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    tekd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_op    (r_op),
        .i_byte  (r_byte),
        .o_evt   (evt)
    );

    assign elapsed = r_time - r_last_time;
    assign rep = evt.track && r_last_valid && (r_last_code == evt.code)
              && ((evt.code != K_CHAR && evt.code != K_CTRL) || r_last_char == evt.ch)
              && (elapsed < TIME_BITS'(r_window));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_window     <= 16'd50;
            r_last_code  <= 5'd0;
            r_last_char  <= 7'd0;
            r_last_valid <= 1'b0;
            r_last_time  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && evt.valid;
            end
            if (step && evt.valid && evt.track) begin
                r_last_code  <= evt.code;
                r_last_char  <= evt.ch;
                r_last_valid <= 1'b1;
                r_last_time  <= r_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_op   <= i_in.op;
            r_byte <= i_in.data_byte;
            r_time <= i_in.time_ms;
        end
        if (step && evt.valid) begin
            r_out     <= evt;
            r_out_rep <= rep;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_out.kind;
    assign o_out.key_code     = r_out.code;
    assign o_out.character    = r_out.ch;
    assign o_out.shift        = r_out.sh;
    assign o_out.ctrl         = r_out.ct;
    assign o_out.alt          = r_out.al;
    assign o_out.repeat_res   = r_out_rep;
    assign o_out.mouse_x      = r_out.mx;
    assign o_out.mouse_y      = r_out.my;
    assign o_out.mouse_button = r_out.btn;
    assign o_out.scroll_down  = r_out.scroll_dn;

endmodule

@@ rtl/tekd_checker.sv @@
// tekd_checker: port-level assertions for terminal_escape_key_decoder.
// Depends on tekd_pkg; attached to the top level by the bind below.
module tekd_checker import tekd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_event_kind,
    input logic [4:0]  i_key_code,
    input logic [6:0]  i_character,
    input logic        i_shift,
    input logic        i_ctrl,
    input logic        i_alt,
    input logic        i_repeat_res,
    input logic [15:0] i_mouse_x,
    input logic [15:0] i_mouse_y,
    input logic [1:0]  i_mouse_button,
    input logic        i_scroll_down
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_key_no_mouse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind == EV_KEY |->
            i_mouse_x == 16'd0 && i_mouse_y == 16'd0 && i_mouse_button == 2'd0
            && !i_scroll_down)
        else $error("key event carries mouse fields");

    a_mouse_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind != EV_KEY |->
            i_key_code == 5'd0 && i_character == 7'd0 && !i_shift && !i_ctrl
            && !i_alt && !i_repeat_res)
        else $error("mouse event carries key fields");

    a_escape_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_repeat_res |-> i_event_kind == EV_KEY && i_key_code != K_ESCAPE)
        else $error("repeat flagged on lone escape or mouse event");

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_event_kind   (o_out.event_kind),
    .i_key_code     (o_out.key_code),
    .i_character    (o_out.character),
    .i_shift        (o_out.shift),
    .i_ctrl         (o_out.ctrl),
    .i_alt          (o_out.alt),
    .i_repeat_res   (o_out.repeat_res),
    .i_mouse_x      (o_out.mouse_x),
    .i_mouse_y      (o_out.mouse_y),
    .i_mouse_button (o_out.mouse_button),
    .i_scroll_down  (o_out.scroll_down)
);
